>>> rtl/core/rqt_pkg.sv
// shared constants and request codes for the rotation quadrant tiler
package rqt_pkg;

    localparam int RQT_MAX_SIDE   = 16;
    localparam int RQT_DATA_WIDTH = 16;

    localparam int IDX_W  = 5;
    localparam int VAL_W  = 16;
    localparam int SIZE_W = 5;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // register index of size_in_use on the configuration port
    localparam logic REG_SIZE = 1'b0;

endpackage

>>> rtl/core/rotation_quadrant_tiler.sv
// rotation quadrant tiler: element store with a 2n-by-2n rotated tiling read view
//
// Requests enter on start with i_req_type, i_row_index, i_col_index and
// i_write_value; a beat is taken on any edge where start is high and busy is low.
// A write (req 0) stores one element at (row, col) of the n-by-n source and gives
// no result; writes outside n by n are dropped. A read (req 1) gives one result
// on o_out_value / o_coord_error, marked by o_valid for exactly one cycle, on the
// cycle after the request was taken. Reads outside 2n by 2n return zero with
// o_coord_error set. The receiver cannot stall, so results are never held.
// Throughput is one request per cycle: busy stays low. Each request costs one
// access of the single-port element memory, whose read is registered; a write
// is visible to a read on the very next cycle. The side length n sits in the
// size register at byte address 0 of the APB-style port; the user must write it
// only while no read is in flight, as the block itself does not enforce this.
// Reset sets n to 16 and drops any pending result; the element memory is not
// cleared and an entry must be written before it is read.
module rotation_quadrant_tiler
    import rqt_pkg::*;
#(
    parameter int MAX_SIDE   = RQT_MAX_SIDE,
    parameter int DATA_WIDTH = RQT_DATA_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    start,
    output logic                    busy,
    input  logic                    i_req_type,
    input  logic [IDX_W-1:0]        i_row_index,
    input  logic [IDX_W-1:0]        i_col_index,
    input  logic signed [VAL_W-1:0] i_write_value,

    output logic                    o_valid,
    output logic signed [VAL_W-1:0] o_out_value,
    output logic                    o_coord_error,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = 8;

    // configuration register
    logic [SIZE_W-1:0] r_size;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SIZE);
    assign prdata = (paddr[2] == REG_SIZE) ? {{(32-SIZE_W){1'b0}}, r_size} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (cfg_wr) begin
            r_size <= pwdata[SIZE_W-1:0];
        end
    end

    // address mapping
    logic               accept;
    logic [IDX_W-1:0]   side_n;
    logic [IDX_W:0]     side_2n;
    logic               lower;
    logic               right;
    logic               rd_err;
    logic [IDX_W-1:0]   ii;
    logic [IDX_W-1:0]   jj;
    logic [IDX_W-1:0]   src_row;
    logic [IDX_W-1:0]   src_col;
    logic [IDX_W-1:0]   mem_row;
    logic [IDX_W-1:0]   mem_col;
    logic [AW-1:0]      mem_addr;
    logic               wr_en;
    logic               rd_en;
    logic [DATA_WIDTH-1:0] wr_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign side_n  = ({{(CMP_W-SIZE_W){1'b0}}, r_size} > CMP_W'(MAX_SIDE))
                   ? IDX_W'(MAX_SIDE) : r_size;
    assign side_2n = {side_n, 1'b0};

    assign lower  = i_row_index >= side_n;
    assign right  = i_col_index >= side_n;
    assign rd_err = ({1'b0, i_row_index} >= side_2n) || ({1'b0, i_col_index} >= side_2n);
    assign ii     = lower ? (i_row_index - side_n) : i_row_index;
    assign jj     = right ? (i_col_index - side_n) : i_col_index;

    always_comb begin
        case ({lower, right})
            2'b00: begin
                src_row = ii;
                src_col = jj;
            end
            2'b01: begin
                src_row = side_n - 5'd1 - jj;
                src_col = ii;
            end
            2'b11: begin
                src_row = side_n - 5'd1 - ii;
                src_col = side_n - 5'd1 - jj;
            end
            default: begin
                src_row = jj;
                src_col = side_n - 5'd1 - ii;
            end
        endcase
    end

    assign rd_en   = accept && (i_req_type == REQ_READ);
    assign wr_en   = accept && (i_req_type == REQ_WRITE) && !lower && !right;
    assign mem_row = (i_req_type == REQ_WRITE) ? i_row_index : src_row;
    assign mem_col = (i_req_type == REQ_WRITE) ? i_col_index : src_col;
    // row*MAX_SIDE + col, both indices below MAX_SIDE here
    assign mem_addr = AW'(AW'(mem_row) * AW'(MAX_SIDE)) + AW'(mem_col);

    generate
        if (DATA_WIDTH <= VAL_W) begin : g_wr_narrow
            assign wr_data = i_write_value[DATA_WIDTH-1:0];
        end else begin : g_wr_wide
            assign wr_data = {{(DATA_WIDTH-VAL_W){1'b0}}, i_write_value};
        end
    endgenerate

    // element memory, one access per cycle, registered read
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic                  r_rd_pend;
    logic                  r_rd_err;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[mem_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[mem_addr];
            r_rd_err  <= rd_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= rd_en;
        end
    end

    // result beat
    logic [VAL_W-1:0] rd_ext;

    generate
        if (DATA_WIDTH >= VAL_W) begin : g_rd_wide
            assign rd_ext = r_rd_data[VAL_W-1:0];
        end else begin : g_rd_narrow
            assign rd_ext = {{(VAL_W-DATA_WIDTH){r_rd_data[DATA_WIDTH-1]}}, r_rd_data};
        end
    endgenerate

    assign o_valid       = r_rd_pend;
    assign o_coord_error = r_rd_pend && r_rd_err;
    assign o_out_value   = (r_rd_pend && !r_rd_err) ? $signed(rd_ext) : '0;

    // checks
    a_result_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && (i_req_type == REQ_READ)))
        else $error("result beat without a read request");

    a_read_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> o_valid)
        else $error("read request gave no result beat");

    a_no_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == REQ_WRITE)) |=> !o_valid)
        else $error("write request gave a result beat");

    a_src_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && !rd_err) |-> ((src_row < side_n) && (src_col < side_n)))
        else $error("mapped source coordinate outside the source square");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && rd_err) |=> (o_coord_error && (o_out_value == '0)))
        else $error("coordinate error without zero value");

endmodule

>>> tb/tb_top.sv
// testbench for the rotation quadrant tiler: directed table then random requests, predictor-checked
`timescale 1ns / 1ps

module tb_top;
    import rqt_pkg::*;

    localparam int STORE_DEPTH = RQT_MAX_SIDE * RQT_MAX_SIDE;
    localparam int REG_SPARE   = 1;
    localparam logic [2:0] ADDR_SIZE  = 3'(4 * REG_SIZE);
    localparam logic [2:0] ADDR_SPARE = 3'(4 * REG_SPARE);
    localparam int READ_LAT    = 2;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 56;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    err;
    } t_tile_beat;

    typedef struct {
        t_row_kind               kind;
        logic                    req;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        bit                      typed;
        t_tile_beat              want;
        logic [2:0]              reg_addr;
        logic [31:0]             reg_data;
    } t_stim_row;

    logic                    i_clk;
    logic                    i_rst_n       = 1'b0;
    logic                    start         = 1'b0;
    logic                    busy;
    logic                    i_req_type    = REQ_WRITE;
    logic [IDX_W-1:0]        i_row_index   = '0;
    logic [IDX_W-1:0]        i_col_index   = '0;
    logic signed [VAL_W-1:0] i_write_value = '0;
    logic                    o_valid;
    logic signed [VAL_W-1:0] o_out_value;
    logic                    o_coord_error;
    logic                    psel          = 1'b0;
    logic                    penable       = 1'b0;
    logic                    pwrite        = 1'b0;
    logic [2:0]              paddr         = '0;
    logic [31:0]             pwdata        = '0;
    logic [31:0]             prdata;
    logic                    pready;

    // predictor state
    logic signed [VAL_W-1:0] src_store [STORE_DEPTH];
    bit                      src_written [STORE_DEPTH];
    logic [SIZE_W-1:0]       size_reg;

    t_tile_beat pending_reads[$];
    t_stim_row  stim_tab[$];
    t_tile_beat want_beat;
    int         fail_count = 0;
    int         burst_left = 0;

    rotation_quadrant_tiler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .o_out_value   (o_out_value),
        .o_coord_error (o_coord_error),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int eff_side();
        return (size_reg > RQT_MAX_SIDE) ? RQT_MAX_SIDE : int'(size_reg);
    endfunction

    // maps an output coordinate of the tiled view to its source entry
    function automatic t_tile_beat tile_read(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                                             output int src);
        t_tile_beat b;
        int n, ri, ci, i, j, sr, sc;
        n  = eff_side();
        ri = int'(r);
        ci = int'(c);
        src = -1;
        b.value = '0;
        b.err   = 1'b1;
        if (ri >= 2 * n || ci >= 2 * n)
            return b;
        i = (ri >= n) ? ri - n : ri;
        j = (ci >= n) ? ci - n : ci;
        if (ri < n && ci < n) begin
            sr = i;
            sc = j;
        end else if (ri < n) begin
            sr = n - 1 - j;
            sc = i;
        end else if (ci >= n) begin
            sr = n - 1 - i;
            sc = n - 1 - j;
        end else begin
            sr = j;
            sc = n - 1 - i;
        end
        src = sr * RQT_MAX_SIDE + sc;
        b.value = src_store[src];
        b.err   = 1'b0;
        return b;
    endfunction

    task automatic dir_item(input logic req, input int r, input int c, input logic [15:0] v);
        t_stim_row s;
        s = '{kind: ROW_ITEM, req: req, row: r[IDX_W-1:0], col: c[IDX_W-1:0], value: v,
              typed: 1'b0, want: '0, reg_addr: '0, reg_data: '0};
        stim_tab.push_back(s);
    endtask

    task automatic dir_check(input int r, input int c, input logic [15:0] ev, input logic ee);
        t_stim_row s;
        s = '{kind: ROW_ITEM, req: REQ_READ, row: r[IDX_W-1:0], col: c[IDX_W-1:0], value: '0,
              typed: 1'b1, want: '{value: ev, err: ee}, reg_addr: '0, reg_data: '0};
        stim_tab.push_back(s);
    endtask

    task automatic dir_reg(input logic [2:0] addr, input logic [31:0] data);
        t_stim_row s;
        s = '{kind: ROW_REG, req: REQ_WRITE, row: '0, col: '0, value: '0,
              typed: 1'b0, want: '0, reg_addr: addr, reg_data: data};
        stim_tab.push_back(s);
    endtask

    // drives one request, waits for it to be taken, then updates the predictor
    task automatic issue_request(input logic req, input logic [IDX_W-1:0] r,
                                 input logic [IDX_W-1:0] c, input logic signed [VAL_W-1:0] v,
                                 input bit typed, input t_tile_beat typed_want);
        t_tile_beat b;
        int src, n;
        start         <= 1'b1;
        i_req_type    <= req;
        i_row_index   <= r;
        i_col_index   <= c;
        i_write_value <= v;
        do @(posedge i_clk); while (busy);
        n = eff_side();
        if (req == REQ_WRITE) begin
            if (int'(r) < n && int'(c) < n) begin
                src_store[int'(r) * RQT_MAX_SIDE + int'(c)]   = v;
                src_written[int'(r) * RQT_MAX_SIDE + int'(c)] = 1'b1;
            end
        end else begin
            b = tile_read(r, c, src);
            pending_reads.push_back(typed ? typed_want : b);
        end
    endtask

    // sender bursts with random gaps, now and then a long stretch with none
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(0, 6);
        end
    endtask

    // lets every pending read come back, bounded
    task automatic settle();
        int waited;
        start <= 1'b0;
        waited = 0;
        while (pending_reads.size() != 0 && waited < 20) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (READ_LAT) @(posedge i_clk);
        if (pending_reads.size() != 0) begin
            fail_count++;
            $display("%0t: %0d read results never came back", $time, pending_reads.size());
            pending_reads.delete();
        end
    endtask

    // apb write, then read back the size register
    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_SIZE)
            size_reg = data[SIZE_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_SIZE;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(size_reg)) begin
            fail_count++;
            $display("%0t: size readback expected %0d got %0d", $time, size_reg, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_request();
        logic req;
        logic [IDX_W-1:0] r, c;
        logic signed [VAL_W-1:0] v;
        t_tile_beat b;
        int n, src;
        n   = eff_side();
        req = $urandom_range(0, 1) ? REQ_READ : REQ_WRITE;
        if (n > 0 && $urandom_range(0, 9) < 7) begin
            if (req == REQ_READ) begin
                r = IDX_W'($urandom_range(0, 2 * n - 1));
                c = IDX_W'($urandom_range(0, 2 * n - 1));
            end else begin
                r = IDX_W'($urandom_range(0, n - 1));
                c = IDX_W'($urandom_range(0, n - 1));
            end
        end else begin
            r = IDX_W'($urandom_range(0, 31));
            c = IDX_W'($urandom_range(0, 31));
        end
        v = VAL_W'($urandom);
        // a read that would land on an unwritten entry turns into a write of that entry
        if (req == REQ_READ) begin
            b = tile_read(r, c, src);
            if (src >= 0 && !src_written[src]) begin
                req = REQ_WRITE;
                r   = IDX_W'(src / RQT_MAX_SIDE);
                c   = IDX_W'(src % RQT_MAX_SIDE);
            end
        end
        issue_request(req, r, c, v, 1'b0, '0);
        pace_sender();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            if (pending_reads.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result value %0d error %b",
                         $time, o_out_value, o_coord_error);
            end else begin
                want_beat = pending_reads.pop_front();
                if (o_valid !== 1'b1) begin
                    fail_count++;
                    $display("%0t: valid expected 1 got %b", $time, o_valid);
                end
                if (o_out_value !== want_beat.value) begin
                    fail_count++;
                    $display("%0t: out_value expected %0d got %0d",
                             $time, want_beat.value, o_out_value);
                end
                if (o_coord_error !== want_beat.err) begin
                    fail_count++;
                    $display("%0t: coord_error expected %b got %b",
                             $time, want_beat.err, o_coord_error);
                end
            end
        end
    end

    initial begin
        int sz;
        size_reg = SIZE_RESET;
        foreach (src_written[k]) begin
            src_written[k] = 1'b0;
            src_store[k]   = '0;
        end

        // corners and every quadrant at full size
        dir_item(REQ_WRITE, 0, 0, 16'h7FFF);
        dir_item(REQ_WRITE, 15, 15, 16'h8000);
        dir_item(REQ_WRITE, 0, 15, 16'h0001);
        dir_item(REQ_WRITE, 15, 0, 16'hFFFF);
        dir_item(REQ_WRITE, 16, 31, 16'h5A5A);    // outside the source, dropped
        dir_check(0, 0, 16'h7FFF, 1'b0);
        dir_check(15, 15, 16'h8000, 1'b0);
        dir_check(0, 16, 16'hFFFF, 1'b0);
        dir_check(16, 16, 16'h8000, 1'b0);
        dir_check(31, 31, 16'h7FFF, 1'b0);
        dir_check(16, 0, 16'h0001, 1'b0);
        dir_check(0, 31, 16'h7FFF, 1'b0);
        // small side: rotations plus reads past 2n
        dir_reg(ADDR_SIZE, 32'd2);
        dir_item(REQ_WRITE, 1, 0, 16'h1234);
        dir_item(REQ_WRITE, 0, 1, 16'h0ABC);
        dir_item(REQ_WRITE, 1, 1, 16'h5678);
        dir_item(REQ_WRITE, 2, 0, 16'h1111);      // outside n, dropped
        dir_item(REQ_READ, 0, 2, 16'h0000);
        dir_item(REQ_READ, 2, 1, 16'hFFFF);
        dir_check(3, 3, 16'h7FFF, 1'b0);
        dir_check(4, 0, 16'h0000, 1'b1);
        dir_check(0, 31, 16'h0000, 1'b1);
        // empty source
        dir_reg(ADDR_SIZE, 32'd0);
        dir_check(0, 0, 16'h0000, 1'b1);
        dir_item(REQ_WRITE, 0, 0, 16'h2222);
        // oversize clamps to the maximum; unknown register leaves size alone
        dir_reg(ADDR_SIZE, 32'd31);
        dir_reg(ADDR_SPARE, 32'd1);
        dir_check(31, 31, 16'h7FFF, 1'b0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_tab[k]) begin
            if (stim_tab[k].kind == ROW_REG) begin
                settle();
                cfg_write(stim_tab[k].reg_addr, stim_tab[k].reg_data);
            end else begin
                issue_request(stim_tab[k].req, stim_tab[k].row, stim_tab[k].col,
                              stim_tab[k].value, stim_tab[k].typed, stim_tab[k].want);
                pace_sender();
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: sz = 16;
                1: sz = 1;
                2: sz = $urandom_range(2, 15);
                3: sz = 0;
                4: sz = 31;
                5: sz = $urandom_range(17, 30);
                6: sz = $urandom_range(2, 15);
                default: sz = 16;
            endcase
            settle();
            cfg_write(ADDR_SIZE, 32'(sz));
            repeat (PHASE_BEATS) random_request();
        end

        settle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> rotation_quadrant_tiler.f
rtl/core/rqt_pkg.sv
rtl/core/rotation_quadrant_tiler.sv
tb/tb_top.sv
